[hw/rtl/sppt_pkg.sv]
// Shared types and constants for the strong probable prime test block.
// No dependencies; imported by the top level and its checker.
`default_nettype none

package sppt_pkg;

  // Fixed width of the witness and modulus ports.
  localparam int unsigned FIELD_W = 31;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPLIT,
    S_REDUCE,
    S_PSQ,
    S_PMUL,
    S_TEST,
    S_XSQ,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

[hw/rtl/sppt_mulmod.sv]
// Bit-serial modular multiplier: product = a * b mod n, one bit of b per cycle.
// Stand-alone; used by strong_probable_prime_test_top.
`default_nettype none

module sppt_mulmod #(
  parameter int unsigned MOD_BITS = 31
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [MOD_BITS-1:0] mcand_i,
  input  wire logic [MOD_BITS-1:0] mplier_i,
  input  wire logic [MOD_BITS-1:0] modulus_i,
  output logic                     busy_o,
  output logic                     done_o,
  output logic [MOD_BITS-1:0]      product_o
);

  localparam int unsigned CW = $clog2(MOD_BITS + 1);

  logic [MOD_BITS-1:0] acc_q, acc_d;
  logic [MOD_BITS-1:0] mcand_q;
  logic [MOD_BITS-1:0] mod_q;
  logic [MOD_BITS-1:0] mplier_q;
  logic [CW-1:0]       cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [MOD_BITS:0] dbl, dbl_r, sum, sum_r, mod_ext;

  // Horner step: acc = 2*acc + bit*a, each partial result kept below n.
  always_comb begin
    mod_ext = {1'b0, mod_q};
    dbl     = {acc_q, 1'b0};
    dbl_r   = (dbl >= mod_ext) ? dbl - mod_ext : dbl;
    sum     = dbl_r + (mplier_q[MOD_BITS-1] ? {1'b0, mcand_q} : '0);
    sum_r   = (sum >= mod_ext) ? sum - mod_ext : sum;
    acc_d   = sum_r[MOD_BITS-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(MOD_BITS);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      acc_q    <= acc_d;
      mplier_q <= {mplier_q[MOD_BITS-2:0], 1'b0};
    end else if (start_i) begin
      acc_q    <= '0;
      mcand_q  <= mcand_i;
      mplier_q <= mplier_i;
      mod_q    <= modulus_i;
    end
  end

  assign busy_o    = busy_q;
  assign done_o    = done_q;
  assign product_o = acc_q;

endmodule

`default_nettype wire

[hw/rtl/strong_probable_prime_test_top.sv]
// Top level of the strong probable prime (Miller-Rabin) test, one witness per item.
// Depends on sppt_pkg and sppt_mulmod.
//
// Usage: an item (witness_i, modulus_i) is transferred on the input channel
// when in_valid_i and in_ready_o are both high; exactly one result
// (probable_prime_o, invalid_o) is later transferred on the output channel
// when out_valid_o and out_ready_i are both high. Both fields are taken to
// MOD_BITS bits. An even modulus or one below 3 gives invalid_o = 1 and
// probable_prime_o = 0; with the output register free, the block passes
// through its finish state and then sets out_valid_o.
// For a valid modulus the block first strips the factors of two from n - 1,
// reduces the witness modulo n, raises it to the odd part t by left-to-right
// square-and-multiply and then squares up to s - 1 more times. Every modular
// product runs on one bit-serial multiplier, and at most 2*MOD_BITS products
// are needed, so the serial multiplier sets the time an item takes.
// One item is processed at a time: in_ready_o is high only while idle.
// The result sits in an output register, so a new item may be transferred
// while the receiver stalls; the next result then waits until the
// previous one has been taken. Reset returns the block to idle with no
// result pending.
`default_nettype none

module strong_probable_prime_test_top
  import sppt_pkg::*;
#(
  parameter int unsigned MOD_BITS = 31
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [FIELD_W-1:0] witness_i,
  input  wire logic [FIELD_W-1:0] modulus_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic                    probable_prime_o,
  output logic                    invalid_o
);

  localparam int unsigned W  = MOD_BITS;
  localparam int unsigned CW = $clog2(W + 1);

  state_e state_q, state_d;

  // Datapath registers.
  logic [W-1:0]  wit_q, wit_d;     // witness as received
  logic [W-1:0]  mod_q, mod_d;     // modulus n
  logic [W-1:0]  exp_q, exp_d;     // odd part t, shifted out MSB first
  logic [CW-1:0] s_q, s_d;         // power of two in n - 1
  logic [CW-1:0] cnt_q, cnt_d;     // exponent bits or squarings left
  logic [W-1:0]  base_q, base_d;   // witness reduced modulo n
  logic [W-1:0]  x_q, x_d;         // running power
  logic          res_prime_q, res_prime_d;
  logic          res_inv_q, res_inv_d;
  logic          out_valid_q, out_valid_d;
  logic          out_prime_q, out_prime_d;
  logic          out_inv_q, out_inv_d;

  // Inputs taken to the datapath width, padding or truncating as needed.
  logic [FIELD_W+W-1:0] wit_ext, mod_ext;
  logic [W-1:0]         wit_in, mod_in;
  logic                 in_xfer, mod_bad;
  logic [W-1:0]         nm1;

  assign wit_ext = {{W{1'b0}}, witness_i};
  assign mod_ext = {{W{1'b0}}, modulus_i};
  assign wit_in  = wit_ext[W-1:0];
  assign mod_in  = mod_ext[W-1:0];
  assign mod_bad = (mod_in < W'(3)) || !mod_in[0];
  assign in_xfer = in_valid_i && in_ready_o;
  assign nm1     = mod_q - W'(1);

  // Modular multiplier and its operand selection.
  logic         mm_start, mm_busy, mm_done;
  logic [W-1:0] mm_mcand, mm_mplier, mm_prod;
  logic         mul_state;

  always_comb begin
    mul_state = 1'b0;
    mm_mcand  = x_q;
    mm_mplier = x_q;
    case (state_q)
      S_REDUCE: begin
        // Reducing the witness is the product 1 * witness modulo n.
        mul_state = 1'b1;
        mm_mcand  = W'(1);
        mm_mplier = wit_q;
      end
      S_PSQ, S_XSQ: begin
        mul_state = 1'b1;
      end
      S_PMUL: begin
        mul_state = 1'b1;
        mm_mcand  = base_q;
      end
      default: begin
        mul_state = 1'b0;
      end
    endcase
    mm_start = mul_state && !mm_busy && !mm_done;
  end

  sppt_mulmod #(
    .MOD_BITS (W)
  ) u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mm_start),
    .mcand_i   (mm_mcand),
    .mplier_i  (mm_mplier),
    .modulus_i (mod_q),
    .busy_o    (mm_busy),
    .done_o    (mm_done),
    .product_o (mm_prod)
  );

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          state_d = mod_bad ? S_FINISH : S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (exp_q[0]) begin
          state_d = S_REDUCE;
        end
      end
      S_REDUCE: begin
        if (mm_done) begin
          state_d = S_PSQ;
        end
      end
      S_PSQ: begin
        if (mm_done) begin
          if (exp_q[W-1]) begin
            state_d = S_PMUL;
          end else if (cnt_q == CW'(1)) begin
            state_d = S_TEST;
          end
        end
      end
      S_PMUL: begin
        if (mm_done) begin
          state_d = (cnt_q == CW'(1)) ? S_TEST : S_PSQ;
        end
      end
      S_TEST: begin
        if ((x_q == W'(1)) || (x_q == nm1) || (cnt_q == '0)) begin
          state_d = S_FINISH;
        end else begin
          state_d = S_XSQ;
        end
      end
      S_XSQ: begin
        if (mm_done && ((mm_prod == nm1) || (cnt_q == CW'(1)))) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    wit_d       = wit_q;
    mod_d       = mod_q;
    exp_d       = exp_q;
    s_d         = s_q;
    cnt_d       = cnt_q;
    base_d      = base_q;
    x_d         = x_q;
    res_prime_d = res_prime_q;
    res_inv_d   = res_inv_q;
    out_prime_d = out_prime_q;
    out_inv_d   = out_inv_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          wit_d       = wit_in;
          mod_d       = mod_in;
          // n is odd, so n - 1 halved is n shifted right by one.
          exp_d       = {1'b0, mod_in[W-1:1]};
          s_d         = CW'(1);
          res_prime_d = 1'b0;
          res_inv_d   = mod_bad;
        end
      end
      S_SPLIT: begin
        if (!exp_q[0]) begin
          exp_d = {1'b0, exp_q[W-1:1]};
          s_d   = s_q + CW'(1);
        end
      end
      S_REDUCE: begin
        if (mm_done) begin
          base_d = mm_prod;
          x_d    = W'(1);
          cnt_d  = CW'(W);
        end
      end
      S_PSQ: begin
        if (mm_done) begin
          x_d = mm_prod;
          if (!exp_q[W-1]) begin
            exp_d = {exp_q[W-2:0], 1'b0};
            cnt_d = (cnt_q == CW'(1)) ? s_q - CW'(1) : cnt_q - CW'(1);
          end
        end
      end
      S_PMUL: begin
        if (mm_done) begin
          x_d   = mm_prod;
          exp_d = {exp_q[W-2:0], 1'b0};
          cnt_d = (cnt_q == CW'(1)) ? s_q - CW'(1) : cnt_q - CW'(1);
        end
      end
      S_TEST: begin
        res_prime_d = (x_q == W'(1)) || (x_q == nm1);
      end
      S_XSQ: begin
        if (mm_done) begin
          x_d         = mm_prod;
          cnt_d       = cnt_q - CW'(1);
          res_prime_d = (mm_prod == nm1);
        end
      end
      S_FINISH: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_prime_d = res_prime_q;
          out_inv_d   = res_inv_q;
        end
      end
      default: begin
        out_valid_d = out_valid_q && !out_ready_i;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wit_q       <= wit_d;
    mod_q       <= mod_d;
    exp_q       <= exp_d;
    s_q         <= s_d;
    cnt_q       <= cnt_d;
    base_q      <= base_d;
    x_q         <= x_d;
    res_prime_q <= res_prime_d;
    res_inv_q   <= res_inv_d;
    out_prime_q <= out_prime_d;
    out_inv_q   <= out_inv_d;
  end

  assign in_ready_o       = (state_q == S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign probable_prime_o = out_prime_q;
  assign invalid_o        = out_inv_q;

endmodule

`default_nettype wire

[hw/rtl/sppt_checker.sv]
// Port-level checker for strong_probable_prime_test_top, with its bind statement.
// Depends on sppt_pkg.
`default_nettype none

module sppt_checker
  import sppt_pkg::*;
(
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_ready_i,
  input wire logic [FIELD_W-1:0] witness_i,
  input wire logic [FIELD_W-1:0] modulus_i,
  input wire logic               out_valid_i,
  input wire logic               out_ready_i,
  input wire logic               probable_prime_i,
  input wire logic               invalid_i
);

  // An offered item that is not taken stays offered and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_i |=> in_valid_i && $stable(witness_i)
      && $stable(modulus_i))
    else $error("waiting input item changed or vanished");

  // A result that is not taken holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(probable_prime_i)
      && $stable(invalid_i))
    else $error("stalled result changed or vanished");

  // An invalid modulus never carries a prime verdict.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && invalid_i |-> !probable_prime_i)
    else $error("invalid result reports a probable prime");

  // After an input transfer the block is busy with that item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("input accepted again while an item is in progress");

  // A new result only appears at the end of work on an item.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("result appeared while idle");

endmodule

bind strong_probable_prime_test_top sppt_checker u_sppt_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_ready_i       (in_ready_o),
  .witness_i        (witness_i),
  .modulus_i        (modulus_i),
  .out_valid_i      (out_valid_o),
  .out_ready_i      (out_ready_i),
  .probable_prime_i (probable_prime_o),
  .invalid_i        (invalid_o)
);

`default_nettype wire

[sim/tb_top.sv]
// Self-checking testbench for strong_probable_prime_test_top, the Miller-Rabin test block.
// Depends on sppt_pkg and the block's RTL; holds its own verdict model and a small scoreboard.

module tb_top;
  import sppt_pkg::*;

  // Datapath width of the block under test. Both fields are already this wide.
  localparam int unsigned MOD_BITS = 31;

  // Worst-case cycles for one item. It sets both the settling time at the end
  // and the scale of the longer sender gaps.
  localparam int unsigned ITEM_CYCLES = 2 * MOD_BITS * (MOD_BITS + 2) + MOD_BITS + 3;

  // About 145 items plus their gaps and stalls; the limit allows several times
  // the time that they need.
  localparam longint unsigned TIMEOUT_CYCLES = 2_500_000;
  localparam int unsigned CLK_HALF = 4;

  localparam int unsigned PHASE_COUNT = 4;
  localparam int unsigned ITEMS_PER_PHASE = 30;

  // Directed items: zero and tiny moduli, the largest even modulus, the
  // largest (prime) modulus with witnesses zero, two, n - 1 and n, the
  // smallest valid modulus with every witness class, a base-2 strong
  // pseudoprime, a Carmichael number, moduli with many factors of two in
  // n - 1, and witnesses at or above the modulus that are congruent to 1 and
  // to n - 1.
  localparam int unsigned DIRECTED_COUNT = 23;
  localparam bit [FIELD_W-1:0] DIRECTED_WITNESS [DIRECTED_COUNT] = '{
    2, 5, 2, 7, 2147483647, 0, 2, 2147483646, 1, 2, 3, 0, 2, 2, 3, 2, 3,
    2147483647, 1000000008, 2000000013, 5, 0, 2147483647
  };
  localparam bit [FIELD_W-1:0] DIRECTED_MODULUS [DIRECTED_COUNT] = '{
    0, 1, 2, 2147483646, 2147483647, 2147483647, 2147483647, 2147483647,
    3, 3, 3, 3, 2047, 561, 65537, 1073741825, 998244353,
    1000000007, 1000000007, 1000000007, 2147483629, 0, 1
  };

  // Known primes, strong pseudoprimes and Carmichael numbers, so that the
  // random part produces plenty of probable-prime verdicts.
  localparam int unsigned KNOWN_COUNT = 19;
  localparam bit [FIELD_W-1:0] KNOWN_MODULI [KNOWN_COUNT] = '{
    3, 5, 7, 13, 17, 257, 65537, 7919, 104729, 2047, 1373653, 25326001,
    561, 1729, 1000000007, 998244353, 2147483647, 2147483629, 1073741825
  };

  typedef struct {
    bit [FIELD_W-1:0] witness;
    bit [FIELD_W-1:0] modulus;
    bit               probable_prime;
    bit               invalid;
  } verdict_entry_t;

  // Holds the verdicts that are still to come, in the order of their input
  // transfers, and compares each result transfer with the oldest one.
  class verdict_scoreboard;
    verdict_entry_t awaited[$];
    int unsigned    fault_count;

    function new();
      fault_count = 0;
    endfunction

    // Miller-Rabin verdict for one witness, in 64-bit arithmetic so that the
    // product of two residues never overflows.
    function void strong_prime_verdict(ref verdict_entry_t e);
      bit [63:0]   field_mask;
      bit [63:0]   a;
      bit [63:0]   n;
      bit [63:0]   n_less_one;
      bit [63:0]   odd_part;
      bit [63:0]   acc;
      bit [63:0]   sq;
      bit [63:0]   ex;
      int unsigned twos;
      field_mask = (64'd1 << MOD_BITS) - 64'd1;
      a = 64'(e.witness) & field_mask;
      n = 64'(e.modulus) & field_mask;
      e.probable_prime = 1'b0;
      e.invalid = 1'b0;
      if (n < 64'd3 || n[0] == 1'b0) begin
        e.invalid = 1'b1;
        return;
      end
      n_less_one = n - 64'd1;
      odd_part = n_less_one;
      twos = 0;
      while (odd_part[0] == 1'b0) begin
        odd_part = odd_part >> 1;
        twos++;
      end
      // Right-to-left square-and-multiply; the block works left to right, but
      // the residue is the same.
      acc = 64'd1 % n;
      sq = a % n;
      ex = odd_part;
      while (ex != 64'd0) begin
        if (ex[0]) acc = (acc * sq) % n;
        sq = (sq * sq) % n;
        ex = ex >> 1;
      end
      if (acc == 64'd1 || acc == n_less_one) begin
        e.probable_prime = 1'b1;
        return;
      end
      for (int unsigned i = 1; i < twos; i++) begin
        acc = (acc * acc) % n;
        if (acc == n_less_one) begin
          e.probable_prime = 1'b1;
          return;
        end
      end
    endfunction

    function void note_item(bit [FIELD_W-1:0] witness, bit [FIELD_W-1:0] modulus);
      verdict_entry_t e;
      e.witness = witness;
      e.modulus = modulus;
      strong_prime_verdict(e);
      awaited.push_back(e);
    endfunction

    function void check_verdict(logic probable_prime, logic invalid);
      verdict_entry_t e;
      if (awaited.size() == 0) begin
        if (fault_count < 10)
          $display("ERROR: result (prime %b, invalid %b) with no item outstanding",
                   probable_prime, invalid);
        fault_count++;
        return;
      end
      e = awaited.pop_front();
      if (probable_prime !== e.probable_prime || invalid !== e.invalid) begin
        if (fault_count < 10)
          $display("ERROR: witness %0d modulus %0d: expected prime %b invalid %b, got %b %b",
                   e.witness, e.modulus, e.probable_prime, e.invalid,
                   probable_prime, invalid);
        fault_count++;
      end
    endfunction
  endclass

  // Every input of the block holds a known value from time zero.
  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               in_valid_i  = 1'b0;
  logic [FIELD_W-1:0] witness_i   = '0;
  logic [FIELD_W-1:0] modulus_i   = '0;
  logic               out_ready_i = 1'b0;
  logic               in_ready_o;
  logic               out_valid_o;
  logic               probable_prime_o;
  logic               invalid_o;

  // Idling rates for the current phase, in percent of cycles.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  verdict_scoreboard book = new();

  strong_probable_prime_test_top #(
    .MOD_BITS(MOD_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .witness_i       (witness_i),
    .modulus_i       (modulus_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .probable_prime_o(probable_prime_o),
    .invalid_o       (invalid_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // Offers one item and returns at the edge of its transfer. Valid is only
  // lowered during a gap, so it is never dropped and raised in the same step.
  // While the sender idles, one item in four waits out a long random gap, so
  // that valid rises at any point of the block's work, including well after
  // it has gone idle.
  task automatic send_item(input bit [FIELD_W-1:0] witness, input bit [FIELD_W-1:0] modulus);
    int unsigned gap;
    gap = 0;
    if (send_idle_pct != 0) begin
      if ($urandom_range(3) == 0) begin
        gap = $urandom_range(ITEM_CYCLES + 200);
      end else begin
        while ($urandom_range(99) < send_idle_pct) gap++;
      end
    end
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    witness_i  <= witness;
    modulus_i  <= modulus;
    // The ready seen on waking is the value that held at this edge.
    do @(posedge clk_i); while (!in_ready_o);
    book.note_item(witness, modulus);
  endtask

  // Random item. Most are well-formed tests: odd moduli across the full range,
  // small odd moduli where primes are common, and known primes and
  // pseudoprimes. The rest are witnesses congruent to 0, 1 or n - 1, and
  // invalid (even or tiny) moduli.
  function automatic void pick_random_item(output bit [FIELD_W-1:0] witness,
                                           output bit [FIELD_W-1:0] modulus);
    int unsigned kind;
    kind = $urandom_range(99);
    witness = FIELD_W'($urandom);
    if (kind < 40) begin
      modulus = FIELD_W'($urandom | 32'd1);
    end else if (kind < 65) begin
      modulus = FIELD_W'(2 * $urandom_range(1000, 1) + 1);
    end else if (kind < 80) begin
      modulus = KNOWN_MODULI[$urandom_range(KNOWN_COUNT - 1)];
      if ($urandom_range(1) == 0) witness = 2;
    end else if (kind < 90) begin
      if ($urandom_range(1) == 0) modulus = KNOWN_MODULI[$urandom_range(KNOWN_COUNT - 1)];
      else modulus = FIELD_W'($urandom | 32'd1);
      case ($urandom_range(4))
        0: witness = 0;
        1: witness = 1;
        2: witness = modulus - FIELD_W'(1);
        3: witness = modulus;
        default: witness = modulus + FIELD_W'(1);
      endcase
    end else begin
      if ($urandom_range(1) == 0) modulus = FIELD_W'($urandom & ~32'd1);
      else modulus = FIELD_W'($urandom_range(2));
    end
  endfunction

  // Result side. Ready is redrawn each cycle; in the stalling phases it is now
  // and then held low for a long stretch, so that a finished result waits in
  // the output register while a new item may already be transferred.
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      if (stall_left != 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else if (recv_stall_pct != 0 && $urandom_range(49) == 0) begin
        stall_left = $urandom_range(80, 10);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) book.check_verdict(probable_prime_o, invalid_o);
    end
  end

  // Stimulus: reset, the directed items with no idling, then four random
  // phases that step through the idling patterns.
  initial begin
    bit [FIELD_W-1:0] witness;
    bit [FIELD_W-1:0] modulus;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < DIRECTED_COUNT; i++)
      send_item(DIRECTED_WITNESS[i], DIRECTED_MODULUS[i]);

    for (int unsigned phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 36; recv_stall_pct = 36; end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        pick_random_item(witness, modulus);
        send_item(witness, modulus);
      end
    end
    in_valid_i <= 1'b0;

    // Let every awaited verdict arrive, then give the block a full item's
    // time to show any stray result.
    while (book.awaited.size() != 0) @(posedge clk_i);
    repeat (ITEM_CYCLES + 64) @(posedge clk_i);

    if (book.fault_count == 0 && book.awaited.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog for a hung handshake or a lost result.
  initial begin
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Test completed with failures");
    $finish;
  end

endmodule
